// ----- src/cfpd_pkg.sv -----
// ----------------------------------------------------------------------------
// cfpd_pkg: shared types and constants of the camera frame parser
// Holds the frame header codes, mode codes, capture depth and the structs
// that travel between the parser, the decoder and the top level.
// ----------------------------------------------------------------------------
package cfpd_pkg;

  localparam int CAPTURE_BYTES = 16;
  localparam int CAP_IDX_W     = 4;

  localparam logic [7:0] HDR_BYTE0 = 8'hAA;
  localparam logic [7:0] HDR_BYTE1 = 8'h29;
  localparam logic [7:0] HDR_BYTE2 = 8'h05;

  localparam logic [7:0] MODE_TRACK  = 8'h41;
  localparam logic [7:0] MODE_LINE   = 8'h42;
  localparam logic [7:0] MODE_ANGLE  = 8'h43;
  localparam logic [7:0] MODE_TARGET = 8'h44;
  localparam logic [7:0] MODE_RANGE  = 8'h45;

  localparam logic [2:0] ID_NONE   = 3'd0;
  localparam logic [2:0] ID_TRACK  = 3'd1;
  localparam logic [2:0] ID_LINE   = 3'd2;
  localparam logic [2:0] ID_ANGLE  = 3'd3;
  localparam logic [2:0] ID_TARGET = 3'd4;
  localparam logic [2:0] ID_RANGE  = 3'd5;

  localparam logic [15:0] CENTER_X  = 16'd80;
  localparam logic [15:0] CENTER_Y  = 16'd60;
  localparam logic [15:0] LIMIT_RST = 16'd1000;

  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  typedef logic [CAPTURE_BYTES-1:0][7:0] cfpd_capture_t;

  // A completed-frame event together with the captured bytes as they stand
  // after the current byte has been written.
  typedef struct packed {
    logic          ok;
    cfpd_capture_t bytes;
  } cfpd_frame_t;

  typedef struct packed {
    logic               frame_ok;
    logic [2:0]         mode_id;
    logic [7:0]         status_byte;
    logic signed [15:0] value_a;
    logic signed [15:0] value_b;
    logic signed [15:0] value_c;
    logic signed [15:0] value_d;
    logic [7:0]         extra_flag;
    logic [7:0]         extra_time;
  } cfpd_result_t;

  // Big-endian word at capture bytes idx and idx+1.
  function automatic logic [15:0] word_at(input cfpd_capture_t b,
                                          input logic [CAP_IDX_W-1:0] idx);
    logic [CAP_IDX_W-1:0] nxt;
    nxt = idx + CAP_IDX_W'(1);
    return {b[idx], b[nxt]};
  endfunction

endpackage

// ----- src/cfpd_if.sv -----
// ----------------------------------------------------------------------------
// cfpd_if: channel interfaces of the camera frame parser
// Input item channel, result channel and configuration write channel, each
// with valid/ready handshake and source/sink modports.
// ----------------------------------------------------------------------------
interface cfpd_item_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] byte_value;
  logic [7:0] tick_ms;

  modport source (output valid, cmd, byte_value, tick_ms, input ready);
  modport sink (input valid, cmd, byte_value, tick_ms, output ready);
endinterface

interface cfpd_result_if;
  logic               valid;
  logic               ready;
  logic               frame_ok;
  logic [2:0]         mode_id;
  logic [7:0]         status_byte;
  logic signed [15:0] value_a;
  logic signed [15:0] value_b;
  logic signed [15:0] value_c;
  logic signed [15:0] value_d;
  logic [7:0]         extra_flag;
  logic [7:0]         extra_time;
  logic               offline;

  modport source (output valid, frame_ok, mode_id, status_byte, value_a, value_b,
                  value_c, value_d, extra_flag, extra_time, offline, input ready);
  modport sink (input valid, frame_ok, mode_id, status_byte, value_a, value_b,
                value_c, value_d, extra_flag, extra_time, offline, output ready);
endinterface

interface cfpd_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// ----- src/camera_frame_parser_decoder_core.sv -----
// ----------------------------------------------------------------------------
// camera_frame_parser_decoder_core: camera link frame parser and decoder
// Parses header, mode, length, payload and sum of camera frames from a UART
// byte stream, decodes good frames by mode and tracks camera timeouts.
// ----------------------------------------------------------------------------
// Usage:
// The item channel carries one transaction per UART byte (cmd 0, byte_value)
// or per timer tick (cmd 1, tick_ms). Every item transaction yields exactly
// one result transaction, in order. A result carries frame_ok and the decoded
// mode fields when the byte closed a frame with a matching sum byte, and all
// zeros otherwise; offline always shows the camera timeout flag after that
// item. The cfg channel writes offline_limit_ms (reset value 1000); it is
// always ready and is meant to be written while no item is in flight.
// An item taken on the item channel sits in the input register, and its result
// is loaded into the result register as soon as that register is free or is
// being emptied. Throughput: one item per cycle while the receiver takes every
// result; the parser step and mode decode form a single short combinational
// stage between the input and result registers.
// When the receiver stalls, the result is held, the input register fills and
// item ready then drops until the result is taken. Reset (rst, synchronous)
// empties both registers, returns the parser to header hunt, clears the
// capture bytes, the offline timer and flag, and restores the limit.
// ----------------------------------------------------------------------------
module camera_frame_parser_decoder_core
  import cfpd_pkg::*;
#(
  parameter int MAX_PAYLOAD = 30
) (
  input  logic            clk,
  input  logic            rst,
  cfpd_item_if.sink       item,
  cfpd_result_if.source   result,
  cfpd_cfg_if.sink        cfg
);

  // Configuration register.
  logic [15:0] limit;

  // Input register stage.
  logic       in_valid;
  logic       in_cmd;
  logic [7:0] in_byte;
  logic [7:0] in_tick;

  // Result register stage.
  logic         out_valid;
  cfpd_result_t out_res;
  logic         out_offline;

  logic         advance;
  cfpd_frame_t  frame;
  cfpd_result_t dec_res;
  logic         offline_next;

  // The input stage moves forward whenever the result register is free or
  // is being emptied in this cycle.
  assign advance    = in_valid && (!out_valid || result.ready);
  assign item.ready = !in_valid || advance;
  assign cfg.ready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= LIMIT_RST;
    end else if (cfg.valid) begin
      limit <= cfg.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (item.ready) begin
      in_valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      in_cmd  <= item.cmd;
      in_byte <= item.byte_value;
      in_tick <= item.tick_ms;
    end
  end

  cfpd_parser #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_parser (
    .clk         (clk),
    .rst         (rst),
    .step        (advance),
    .cmd         (in_cmd),
    .byte_value  (in_byte),
    .tick_ms     (in_tick),
    .limit       (limit),
    .frame       (frame),
    .offline_next(offline_next)
  );

  cfpd_decoder u_decoder (
    .frame(frame),
    .res  (dec_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res     <= dec_res;
      out_offline <= offline_next;
    end
  end

  assign result.valid       = out_valid;
  assign result.frame_ok    = out_res.frame_ok;
  assign result.mode_id     = out_res.mode_id;
  assign result.status_byte = out_res.status_byte;
  assign result.value_a     = out_res.value_a;
  assign result.value_b     = out_res.value_b;
  assign result.value_c     = out_res.value_c;
  assign result.value_d     = out_res.value_d;
  assign result.extra_flag  = out_res.extra_flag;
  assign result.extra_time  = out_res.extra_time;
  assign result.offline     = out_offline;

`ifndef SYNTHESIS
  a_good_frame_online: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_res.frame_ok) |-> !out_offline)
    else $error("a good frame left the offline flag set");

  a_no_frame_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_res.frame_ok) |->
      (out_res.mode_id == ID_NONE && out_res.value_a == 16'sd0 &&
       out_res.value_b == 16'sd0 && out_res.extra_flag == 8'd0))
    else $error("decoded fields set without a completed frame");

  a_advance_fills: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("an advanced item produced no result");
`endif

endmodule

// ----- src/cfpd_parser.sv -----
// ----------------------------------------------------------------------------
// cfpd_parser: frame parser and offline timer
// Tracks the header, length and running sum, captures the first frame bytes
// and keeps the offline timer; state advances once per stepped item.
// ----------------------------------------------------------------------------
module cfpd_parser
  import cfpd_pkg::*;
#(
  parameter int MAX_PAYLOAD = 30
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        step,
  input  logic        cmd,
  input  logic [7:0]  byte_value,
  input  logic [7:0]  tick_ms,
  input  logic [15:0] limit,
  output cfpd_frame_t frame,
  output logic        offline_next
);

  localparam int POS_W = $clog2(MAX_PAYLOAD + 6);
  localparam int LEN_W = $clog2(MAX_PAYLOAD + 1);

  localparam logic [POS_W-1:0] POS_HUNT = POS_W'(0);
  localparam logic [POS_W-1:0] POS_HDR1 = POS_W'(1);
  localparam logic [POS_W-1:0] POS_HDR2 = POS_W'(2);
  localparam logic [POS_W-1:0] POS_MODE = POS_W'(3);
  localparam logic [POS_W-1:0] POS_LEN  = POS_W'(4);
  localparam logic [POS_W-1:0] POS_BODY = POS_W'(5);

  logic [POS_W-1:0] pos, pos_next;
  logic [LEN_W-1:0] len, len_next;
  logic [7:0]       sum, sum_next;
  cfpd_capture_t    capture, capture_next;
  logic [15:0]      timer, timer_next;
  logic             offline, offline_flag_next;
  logic             is_byte;
  logic             sum_ok;

  assign is_byte = (cmd == CMD_BYTE);

  always_comb begin
    capture_next = capture;
    if (is_byte && pos < POS_W'(CAPTURE_BYTES)) begin
      capture_next[pos[CAP_IDX_W-1:0]] = byte_value;
    end
  end

  always_comb begin
    pos_next = pos;
    len_next = len;
    sum_next = sum;
    sum_ok   = 1'b0;
    if (is_byte) begin
      priority if (pos == POS_HUNT) begin
        if (byte_value == HDR_BYTE0) begin
          sum_next = byte_value;
          pos_next = POS_HDR1;
        end
      end else if (pos == POS_HDR1) begin
        sum_next = sum + byte_value;
        pos_next = (byte_value == HDR_BYTE1) ? POS_HDR2 : POS_HUNT;
      end else if (pos == POS_HDR2) begin
        sum_next = sum + byte_value;
        pos_next = (byte_value == HDR_BYTE2) ? POS_MODE : POS_HUNT;
      end else if (pos == POS_MODE) begin
        sum_next = sum + byte_value;
        pos_next = POS_LEN;
      end else if (pos == POS_LEN) begin
        sum_next = sum + byte_value;
        if (byte_value <= 8'(MAX_PAYLOAD)) begin
          len_next = LEN_W'(byte_value);
          pos_next = POS_BODY;
        end else begin
          pos_next = POS_HUNT;
        end
      end else if (pos >= POS_W'(len) + POS_BODY) begin
        sum_ok   = (sum == byte_value);
        pos_next = POS_HUNT;
      end else begin
        sum_next = sum + byte_value;
        pos_next = pos + POS_W'(1);
      end
    end
  end

  // A good frame clears the timer; otherwise ticks count up to the limit.
  always_comb begin
    timer_next        = timer;
    offline_flag_next = offline;
    if (sum_ok) begin
      timer_next        = '0;
      offline_flag_next = 1'b0;
    end else if (!is_byte) begin
      if (timer < limit) begin
        timer_next = timer + 16'(tick_ms);
      end else begin
        offline_flag_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos     <= POS_HUNT;
      len     <= '0;
      sum     <= '0;
      capture <= '0;
      timer   <= '0;
      offline <= 1'b0;
    end else if (step) begin
      pos     <= pos_next;
      len     <= len_next;
      sum     <= sum_next;
      capture <= capture_next;
      timer   <= timer_next;
      offline <= offline_flag_next;
    end
  end

  assign frame.ok    = sum_ok;
  assign frame.bytes = capture_next;
  assign offline_next = offline_flag_next;

`ifndef SYNTHESIS
  a_pos_in_frame: assert property (@(posedge clk) disable iff (rst)
    (pos >= POS_BODY) |-> (pos <= POS_W'(len) + POS_BODY))
    else $error("parse position ran past the end of the frame");
`endif

endmodule

// ----- src/cfpd_decoder.sv -----
// ----------------------------------------------------------------------------
// cfpd_decoder: mode decoder of a completed frame
// Maps the mode byte to a mode id and forms the status, the four 16-bit
// values, the flag and the time byte from the captured frame bytes.
// ----------------------------------------------------------------------------
module cfpd_decoder
  import cfpd_pkg::*;
(
  input  cfpd_frame_t  frame,
  output cfpd_result_t res
);

  logic [7:0]  mode;
  logic [7:0]  st;
  logic [15:0] s6, s8, s10, s11, s13;
  logic        st_zero;

  assign mode    = frame.bytes[3];
  assign st      = frame.bytes[5];
  assign st_zero = (st == 8'd0);
  assign s6      = word_at(frame.bytes, CAP_IDX_W'(6));
  assign s8      = word_at(frame.bytes, CAP_IDX_W'(8));
  assign s10     = word_at(frame.bytes, CAP_IDX_W'(10));
  assign s11     = word_at(frame.bytes, CAP_IDX_W'(11));
  assign s13     = word_at(frame.bytes, CAP_IDX_W'(13));

  always_comb begin
    res = '0;
    if (frame.ok) begin
      res.frame_ok = 1'b1;
      priority if (mode == MODE_TRACK) begin
        res.mode_id = ID_TRACK;
        if (st_zero) begin
          res.value_a = CENTER_X - s6;
          res.value_b = CENTER_Y - s8;
        end
      end else if (mode == MODE_LINE) begin
        res.mode_id    = ID_LINE;
        res.value_a    = s6;
        res.value_b    = s8;
        res.value_c    = s11;
        res.value_d    = s13;
        res.extra_flag = frame.bytes[10];
        res.extra_time = frame.bytes[15];
      end else if (mode == MODE_ANGLE) begin
        res.mode_id = ID_ANGLE;
        if (st_zero) begin
          res.value_a = 16'd0 - s6;
          res.value_b = s8;
        end
      end else if (mode == MODE_TARGET) begin
        res.mode_id = ID_TARGET;
        if (st_zero) begin
          res.value_a = CENTER_X - s6;
          res.value_b = CENTER_X - s8;
        end
      end else if (mode == MODE_RANGE) begin
        res.mode_id = ID_RANGE;
        if (!st_zero) begin
          res.value_a = s6;
          res.value_b = s8;
          res.value_c = s10;
        end
      end else begin
        res.mode_id = ID_NONE;
      end
      res.status_byte = (res.mode_id != ID_NONE) ? st : 8'd0;
    end
  end

endmodule

// ----- tb/cfpd_frame_checker.sv -----
// ----------------------------------------------------------------------------
// cfpd_frame_checker: result predictor and scoreboard of the frame parser
// Watches the item, result and configuration channels, predicts the result
// of every accepted item and compares each result transaction in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cfpd_frame_checker
  import cfpd_pkg::*;
#(
  parameter int MAX_PAYLOAD = 30
) (
  input  logic        clk,
  input  logic        rst,
  cfpd_item_if        item,
  cfpd_result_if      result,
  cfpd_cfg_if         cfg,
  output int unsigned mismatch_count,
  output int unsigned reports_pending
);

  typedef struct packed {
    cfpd_result_t fields;
    logic         offline;
  } camera_report_t;

  camera_report_t expected_reports[$];
  int unsigned    mismatches;

  // Local copy of the parser, capture, timer and limit.
  logic [15:0] limit_ms;
  logic [5:0]  parse_pos;
  logic [5:0]  frame_len;
  logic [7:0]  byte_sum;
  logic [7:0]  captured[CAPTURE_BYTES];
  logic [15:0] silence_ms;
  logic        camera_lost;

  function automatic logic [15:0] be_word(int unsigned idx);
    return {captured[idx % CAPTURE_BYTES], captured[(idx + 1) % CAPTURE_BYTES]};
  endfunction

  function automatic cfpd_result_t decode_frame();
    cfpd_result_t r;
    logic [7:0]   st;
    r = '0;
    st = captured[5];
    r.frame_ok = 1'b1;
    case (captured[3])
      MODE_TRACK: begin
        r.mode_id = ID_TRACK;
        if (st == 8'd0) begin
          r.value_a = CENTER_X - be_word(6);
          r.value_b = CENTER_Y - be_word(8);
        end
      end
      MODE_LINE: begin
        r.mode_id    = ID_LINE;
        r.value_a    = be_word(6);
        r.value_b    = be_word(8);
        r.value_c    = be_word(11);
        r.value_d    = be_word(13);
        r.extra_flag = captured[10];
        r.extra_time = captured[15];
      end
      MODE_ANGLE: begin
        r.mode_id = ID_ANGLE;
        if (st == 8'd0) begin
          r.value_a = 16'd0 - be_word(6);
          r.value_b = be_word(8);
        end
      end
      MODE_TARGET: begin
        r.mode_id = ID_TARGET;
        if (st == 8'd0) begin
          r.value_a = CENTER_X - be_word(6);
          r.value_b = CENTER_X - be_word(8);
        end
      end
      MODE_RANGE: begin
        r.mode_id = ID_RANGE;
        if (st != 8'd0) begin
          r.value_a = be_word(6);
          r.value_b = be_word(8);
          r.value_c = be_word(10);
        end
      end
      default: r.mode_id = ID_NONE;
    endcase
    if (r.mode_id != ID_NONE) r.status_byte = st;
    return r;
  endfunction

  task automatic predict_report(input logic c, input logic [7:0] b, input logic [7:0] t,
                                output camera_report_t rep);
    rep = '0;
    if (c == CMD_BYTE) begin
      if (parse_pos < CAPTURE_BYTES) captured[parse_pos] = b;
      if (parse_pos == 6'd0) begin
        if (b == HDR_BYTE0) begin
          byte_sum  = b;
          parse_pos = 6'd1;
        end
      end else if (parse_pos == 6'd1) begin
        byte_sum += b;
        parse_pos = (b == HDR_BYTE1) ? 6'd2 : 6'd0;
      end else if (parse_pos == 6'd2) begin
        byte_sum += b;
        parse_pos = (b == HDR_BYTE2) ? 6'd3 : 6'd0;
      end else if (parse_pos == 6'd3) begin
        byte_sum += b;
        parse_pos = 6'd4;
      end else if (parse_pos == 6'd4) begin
        byte_sum += b;
        if (int'(b) <= MAX_PAYLOAD) begin
          frame_len = b[5:0];
          parse_pos = 6'd5;
        end else begin
          parse_pos = 6'd0;
        end
      end else if (int'(parse_pos) >= int'(frame_len) + 5) begin
        // Sum byte: a match closes a good frame and restarts the timeout.
        if (byte_sum == b) begin
          rep.fields  = decode_frame();
          silence_ms  = 16'd0;
          camera_lost = 1'b0;
        end
        parse_pos = 6'd0;
      end else begin
        byte_sum += b;
        parse_pos += 6'd1;
      end
    end else begin
      if (silence_ms < limit_ms) silence_ms += 16'(t);
      else camera_lost = 1'b1;
    end
    rep.offline = camera_lost;
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  initial begin
    mismatches      = 0;
    mismatch_count  = 0;
    reports_pending = 0;
  end

  always @(posedge clk) begin
    camera_report_t want;
    if (rst) begin
      limit_ms    = LIMIT_RST;
      parse_pos   = '0;
      frame_len   = '0;
      byte_sum    = '0;
      silence_ms  = '0;
      camera_lost = 1'b0;
      for (int i = 0; i < CAPTURE_BYTES; i++) captured[i] = 8'd0;
      expected_reports.delete();
    end else begin
      if (result.valid && result.ready) begin
        if (expected_reports.size() == 0) begin
          $error("result transaction with no expected result pending");
          mismatches++;
        end else begin
          want = expected_reports.pop_front();
          check_field("frame_ok", 16'(want.fields.frame_ok), 16'(result.frame_ok));
          check_field("mode_id", 16'(want.fields.mode_id), 16'(result.mode_id));
          check_field("status_byte", 16'(want.fields.status_byte), 16'(result.status_byte));
          check_field("value_a", want.fields.value_a, result.value_a);
          check_field("value_b", want.fields.value_b, result.value_b);
          check_field("value_c", want.fields.value_c, result.value_c);
          check_field("value_d", want.fields.value_d, result.value_d);
          check_field("extra_flag", 16'(want.fields.extra_flag), 16'(result.extra_flag));
          check_field("extra_time", 16'(want.fields.extra_time), 16'(result.extra_time));
          check_field("offline", 16'(want.offline), 16'(result.offline));
        end
      end
      if (cfg.valid && cfg.ready) limit_ms = cfg.data;
      if (item.valid && item.ready) begin
        predict_report(item.cmd, item.byte_value, item.tick_ms, want);
        expected_reports.push_back(want);
      end
    end
    mismatch_count  <= mismatches;
    reports_pending <= expected_reports.size();
  end

endmodule

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench: top level of the camera frame parser verification
// Drives UART bytes and timer ticks into the parser, stalls the result side
// at random and across one long hold-off, rewrites the offline limit between
// phases and reports the verdict from the checker's mismatch count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench
  import cfpd_pkg::*;
();

  localparam int MAX_LEN     = 30;
  localparam int IDLE_PCT    = 38;
  localparam int HOLD_FROM   = 300;
  localparam int HOLD_LEN    = 250;
  localparam int QUIET_FROM  = 600;
  localparam int QUIET_TO    = 800;
  localparam int CYCLE_LIMIT = 400000;

  logic        clk = 1'b0;
  logic        rst;
  int unsigned cycle_count = 0;
  int unsigned items_sent = 0;
  int unsigned mismatch_count;
  int unsigned reports_pending;

  cfpd_item_if   item_ch();
  cfpd_result_if result_ch();
  cfpd_cfg_if    cfg_ch();

  camera_frame_parser_decoder_core #(
    .MAX_PAYLOAD(MAX_LEN)
  ) dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  cfpd_frame_checker #(
    .MAX_PAYLOAD(MAX_LEN)
  ) u_checker (
    .clk             (clk),
    .rst             (rst),
    .item            (item_ch),
    .result          (result_ch),
    .cfg             (cfg_ch),
    .mismatch_count  (mismatch_count),
    .reports_pending (reports_pending)
  );

  // 12 ns clock period.
  always #6 clk = ~clk;

  // Cycle counter doubles as the watchdog. A run that has not finished by
  // the limit is hung, so it is declared failed right here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // During the quiet window neither side idles, so the block runs at full rate.
  function automatic bit quiet_now();
    return cycle_count >= QUIET_FROM && cycle_count < QUIET_TO;
  endfunction

  // Result receiver. Most of the time ready is random. Once, it is held low
  // for a long stretch while the sender keeps offering, which fills both
  // internal registers and must push back on the item channel.
  initial begin
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (cycle_count == HOLD_FROM) begin
        result_ch.ready <= 1'b0;
        repeat (HOLD_LEN) @(posedge clk);
      end else if (quiet_now()) begin
        result_ch.ready <= 1'b1;
      end else begin
        result_ch.ready <= ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Offers one item and returns once its transaction has been taken. Valid
  // is left high so that a following item goes out back to back; random gap
  // cycles drop it in front of the next offer.
  task automatic push_item(input logic c, input logic [7:0] b, input logic [7:0] t);
    while (!quiet_now() && $urandom_range(99) < IDLE_PCT) begin
      item_ch.valid <= 1'b0;
      @(posedge clk);
    end
    item_ch.valid      <= 1'b1;
    item_ch.cmd        <= c;
    item_ch.byte_value <= b;
    item_ch.tick_ms    <= t;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    items_sent++;
  endtask

  // A UART byte, sometimes preceded by a timer tick. Ticks never disturb the
  // parser, so sprinkling them inside frames checks that they stay separate.
  // The unused field of each item carries random data.
  task automatic send_byte(input logic [7:0] b);
    if ($urandom_range(99) < 8) push_item(CMD_TICK, 8'($urandom), 8'($urandom));
    push_item(CMD_BYTE, b, 8'($urandom));
  endtask

  // The block is only written to while it is idle: stop offering, wait for
  // every predicted result to come back and let the pipeline settle, then do
  // the single configuration transaction.
  task automatic write_offline_limit(input logic [15:0] limit);
    item_ch.valid <= 1'b0;
    @(posedge clk);
    while (reports_pending != 0) @(posedge clk);
    repeat (2) @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= limit;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // One frame with random content. Each part is most often well formed,
  // with a known mode, a length that reaches the whole capture window and a
  // good sum byte. Otherwise it has a broken header, an unknown mode, a
  // short or oversized length, or a wrong sum.
  task automatic send_frame();
    logic [7:0]  hdr[3];
    logic [7:0]  mode;
    logic [7:0]  len;
    logic [7:0]  frame_sum;
    logic [7:0]  b;
    int unsigned roll;
    hdr[0] = HDR_BYTE0;
    hdr[1] = HDR_BYTE1;
    hdr[2] = HDR_BYTE2;
    if ($urandom_range(99) < 6) hdr[$urandom_range(2)] ^= 8'($urandom_range(1, 255));
    if ($urandom_range(99) < 85) mode = MODE_TRACK + 8'($urandom_range(4));
    else mode = 8'($urandom);
    roll = $urandom_range(99);
    if (roll < 70) len = 8'($urandom_range(11, MAX_LEN));
    else if (roll < 90) len = 8'($urandom_range(0, 10));
    else len = 8'($urandom_range(MAX_LEN + 1, 255));
    frame_sum = 8'd0;
    for (int i = 0; i < 3; i++) begin
      send_byte(hdr[i]);
      frame_sum += hdr[i];
    end
    send_byte(mode);
    frame_sum += mode;
    send_byte(len);
    frame_sum += len;
    // An oversized length makes the parser drop the frame at this point.
    if (int'(len) > MAX_LEN) return;
    for (int i = 0; i < int'(len); i++) begin
      b = 8'($urandom);
      // Half of the frames carry a zero status, which selects the other
      // branch of the track, angle, target and range decodes.
      if (i == 0 && $urandom_range(1) == 0) b = 8'd0;
      send_byte(b);
      frame_sum += b;
    end
    if ($urandom_range(99) < 88) send_byte(frame_sum);
    else send_byte(frame_sum ^ 8'($urandom_range(1, 255)));
  endtask

  // Random traffic: mostly frames, with some stray bytes between them, a
  // part of which are lone header starts.
  task automatic run_random(input int unsigned count);
    int unsigned target;
    target = items_sent + count;
    while (items_sent < target) begin
      if ($urandom_range(99) < 15) begin
        repeat ($urandom_range(1, 4))
          send_byte(($urandom_range(99) < 30) ? HDR_BYTE0 : 8'($urandom));
      end else begin
        send_frame();
      end
    end
  endtask

  initial begin
    logic [7:0] line_frame[16];
    logic [7:0] frame_sum;

    rst                <= 1'b1;
    item_ch.valid      <= 1'b0;
    item_ch.cmd        <= CMD_BYTE;
    item_ch.byte_value <= 8'd0;
    item_ch.tick_ms    <= 8'd0;
    cfg_ch.valid       <= 1'b0;
    cfg_ch.data        <= 16'd0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed part. A line-mode frame whose payload holds the extreme
    // words (0xff80, 0x007f, 0xffff, 0x0080) and a nonzero flag and time,
    // then the largest and smallest tick, then a frame whose length byte is
    // one above the maximum and is dropped.
    write_offline_limit(LIMIT_RST);
    line_frame = '{HDR_BYTE0, HDR_BYTE1, HDR_BYTE2, MODE_LINE, 8'd11,
                   8'h00, 8'hFF, 8'h80, 8'h00, 8'h7F, 8'h01,
                   8'hFF, 8'hFF, 8'h00, 8'h80, 8'h55};
    frame_sum = 8'd0;
    foreach (line_frame[i]) begin
      push_item(CMD_BYTE, line_frame[i], 8'hFF);
      frame_sum += line_frame[i];
    end
    push_item(CMD_BYTE, frame_sum, 8'h00);
    push_item(CMD_TICK, 8'hFF, 8'hFF);
    push_item(CMD_TICK, 8'h00, 8'h00);
    push_item(CMD_BYTE, HDR_BYTE0, 8'h00);
    push_item(CMD_BYTE, HDR_BYTE1, 8'h00);
    push_item(CMD_BYTE, HDR_BYTE2, 8'h00);
    push_item(CMD_BYTE, MODE_TRACK, 8'h00);
    push_item(CMD_BYTE, 8'(MAX_LEN + 1), 8'h00);

    // A zero limit declares the camera offline on every tick.
    write_offline_limit(16'd0);
    run_random(30);

    // With the largest limit, a long run of big ticks can push the timer past
    // the top of its range so that it wraps around. The long receiver
    // hold-off and the quiet window fall into this run.
    write_offline_limit(16'hFFFF);
    repeat (300) push_item(CMD_TICK, 8'($urandom), 8'($urandom_range(200, 255)));
    run_random(20);

    write_offline_limit(16'($urandom_range(1, 3000)));
    run_random(50);

    write_offline_limit(16'd1);
    run_random(20);

    write_offline_limit(16'($urandom_range(200, 1200)));
    run_random(30);

    // Drain: stop offering, wait for every expected result, then let the
    // checker's registered counts settle before the verdict.
    item_ch.valid <= 1'b0;
    @(posedge clk);
    while (reports_pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
